@@ sv/kmld_pkg.sv @@
// package for the keyboard matrix layer decoder
// holds keymap rom, key code constants and default sizes; no dependencies
package kmld_pkg;

  localparam int unsigned RowsDef  = 8;
  localparam int unsigned ColsDef  = 16;
  localparam int unsigned SlotsDef = 4;

  localparam logic [7:0] CodeCaps = 8'hC1;
  localparam logic [7:0] CodeFn   = 8'hF0;
  localparam logic [7:0] CodeFnQ  = 8'hF1;
  localparam logic [7:0] CodeFnW  = 8'hF2;
  localparam logic [7:0] CodeFnE  = 8'hF3;

  localparam logic [2:0] LayerLower = 3'd0;
  localparam logic [2:0] LayerUpper = 3'd1;
  localparam logic [2:0] LayerFn    = 3'd2;
  localparam logic [2:0] LayerFnQ   = 3'd3;
  localparam logic [2:0] LayerMedia = 3'd4;
  localparam logic [2:0] LayerFnE   = 3'd5;

  localparam logic [1:0] MediaNone = 2'd0;
  localparam logic [1:0] MediaUp   = 2'd1;
  localparam logic [1:0] MediaDown = 2'd2;
  localparam logic [1:0] MediaMute = 2'd3;

  localparam logic [1:0] MapLower = 2'd0;
  localparam logic [1:0] MapUpper = 2'd1;
  localparam logic [1:0] MapFn    = 2'd2;
  localparam logic [1:0] MapMedia = 2'd3;

  typedef logic [7:0] code_t;

  function automatic logic [1:0] map_for_layer(input logic [2:0] layer);
    logic [1:0] m;
    case (layer)
      LayerUpper: m = MapUpper;
      LayerFn, LayerFnQ, LayerFnE: m = MapFn;
      LayerMedia: m = MapMedia;
      default: m = MapLower;
    endcase
    return m;
  endfunction

  // key code at a matrix row and column for the lower, upper, fn or media map
  function automatic code_t keymap(input logic [1:0] map, input logic [2:0] row,
                                   input logic [3:0] col);
    code_t c;
    logic [6:0] key;
    key = {row, col};
    c = 8'hFF;
    case (key)
      {3'd0, 4'd3}:  c = 8'h80;
      {3'd0, 4'd4}:  c = (map[1]) ? 8'hB1 : 8'h60;
      {3'd0, 4'd7}:  c = (map[1]) ? 8'hC6 : "5";
      {3'd0, 4'd8}:  c = (map[1]) ? 8'hC7 : "6";
      {3'd0, 4'd9}:  c = (map == MapMedia) ? 8'hF2 : (map[1]) ? 8'hCD : "=";
      {3'd0, 4'd11}: c = (map == MapMedia) ? 8'hF0 : (map[1]) ? 8'hCC : "-";
      {3'd1, 4'd4}:  c = (map[1]) ? 8'hC2 : "1";
      {3'd1, 4'd5}:  c = (map[1]) ? 8'hC3 : "2";
      {3'd1, 4'd6}:  c = (map[1]) ? 8'hC4 : "3";
      {3'd1, 4'd7}:  c = (map[1]) ? 8'hC5 : "4";
      {3'd1, 4'd8}:  c = (map[1]) ? 8'hC8 : "7";
      {3'd1, 4'd9}:  c = (map[1]) ? 8'hC9 : "8";
      {3'd1, 4'd10}: c = (map[1]) ? 8'hCA : "9";
      {3'd1, 4'd11}: c = (map == MapMedia) ? 8'hF1 : (map[1]) ? 8'hCB : "0";
      {3'd2, 4'd4}:  c = (map[1]) ? 8'hF1 : (map[0]) ? "Q" : "q";
      {3'd2, 4'd5}:  c = (map[1]) ? 8'hF2 : (map[0]) ? "W" : "w";
      {3'd2, 4'd6}:  c = (map[1]) ? 8'hF3 : (map[0]) ? "E" : "e";
      {3'd2, 4'd7}:  c = (map == MapUpper) ? "R" : "r";
      {3'd2, 4'd8}:  c = (map[1]) ? 8'h27 : (map[0]) ? "O" : "o";
      {3'd2, 4'd9}:  c = (map == MapUpper) ? "I" : "i";
      {3'd2, 4'd10}: c = (map == MapUpper) ? "U" : "u";
      {3'd2, 4'd11}: c = (map[1]) ? 8'h22 : (map[0]) ? "P" : "p";
      {3'd3, 4'd1}:  c = 8'h82;
      {3'd3, 4'd2}:  c = 8'h81;
      {3'd3, 4'd4}:  c = 8'h09;
      {3'd3, 4'd5}:  c = 8'hC1;
      {3'd3, 4'd7}:  c = (map == MapUpper) ? "T" : "t";
      {3'd3, 4'd8}:  c = (map == MapUpper) ? "Y" : "y";
      {3'd3, 4'd9}:  c = 8'h5C;
      {3'd3, 4'd11}: c = 8'h2F;
      {3'd3, 4'd13}: c = (map[1]) ? 8'hD4 : 8'hB2;
      {3'd4, 4'd0}:  c = 8'hF0;
      {3'd4, 4'd4}:  c = (map == MapUpper) ? "A" : "a";
      {3'd4, 4'd5}:  c = (map == MapUpper) ? "S" : "s";
      {3'd4, 4'd6}:  c = (map == MapUpper) ? "D" : "d";
      {3'd4, 4'd7}:  c = (map == MapUpper) ? "F" : "f";
      {3'd4, 4'd8}:  c = (map == MapUpper) ? "J" : "j";
      {3'd4, 4'd9}:  c = (map == MapUpper) ? "K" : "k";
      {3'd4, 4'd10}: c = (map[1]) ? 8'h5B : (map[0]) ? "L" : "l";
      {3'd4, 4'd11}: c = 8'h0A;
      {3'd4, 4'd12}: c = 8'hB0;
      {3'd5, 4'd4}:  c = (map == MapUpper) ? "Z" : "z";
      {3'd5, 4'd5}:  c = (map == MapUpper) ? "X" : "x";
      {3'd5, 4'd6}:  c = (map == MapUpper) ? "C" : "c";
      {3'd5, 4'd8}:  c = (map == MapUpper) ? "N" : "n";
      {3'd5, 4'd9}:  c = (map == MapUpper) ? "M" : "m";
      {3'd5, 4'd10}: c = (map[1]) ? 8'h7B : 8'h2C;
      {3'd5, 4'd11}: c = (map[1]) ? 8'h5D : 8'h3B;
      {3'd5, 4'd13}: c = 8'h85;
      {3'd6, 4'd0}:  c = 8'h83;
      {3'd6, 4'd7}:  c = (map == MapUpper) ? "G" : "g";
      {3'd6, 4'd8}:  c = (map == MapUpper) ? "H" : "h";
      {3'd6, 4'd12}: c = (map[1]) ? 8'hD3 : 8'hDA;
      {3'd6, 4'd14}: c = 8'h20;
      {3'd7, 4'd7}:  c = (map == MapUpper) ? "V" : "v";
      {3'd7, 4'd8}:  c = (map == MapUpper) ? "B" : "b";
      {3'd7, 4'd11}: c = (map[1]) ? 8'h7D : 8'h2E;
      {3'd7, 4'd12}: c = (map[1]) ? 8'hD2 : 8'hD8;
      {3'd7, 4'd14}: c = (map[1]) ? 8'hD6 : 8'hD9;
      {3'd7, 4'd15}: c = (map[1]) ? 8'hD5 : 8'hD7;
      default: c = 8'hFF;
    endcase
    return c;
  endfunction

endpackage

@@ sv/keyboard_matrix_layer_decoder.sv @@
// top level of the keyboard matrix layer decoder
// depends on kmld_pkg, kmld_row_lane, kmld_slot_merge
//
// input channel: one matrix column per beat (column_index_i, row_pressed_i,
// frame_end_i) on in_valid_i / in_ready_o. columns arrive in scan order.
// every row has its own lookup lane; the merge stage packs hits in row order
// into the slot file. the beat with frame_end_i set produces one result on
// out_valid_o / out_ready_i: four key codes, the layer for the next frame,
// the caps led and the media key. other beats produce nothing.
// throughput: one column per cycle; the rom lookup and slot fill finish in
// the cycle of acceptance. the frame end beat loads the output register,
// which frees while a result waits only if the receiver takes it in the
// same cycle; a frame end beat stalls while an unconsumed result is held,
// other columns are always taken.
// reset clears layer, caps state, slots and the output register.
module keyboard_matrix_layer_decoder #(
  parameter int unsigned Rows  = kmld_pkg::RowsDef,
  parameter int unsigned Cols  = kmld_pkg::ColsDef,
  parameter int unsigned Slots = kmld_pkg::SlotsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] column_index_i,
  input  logic [7:0] row_pressed_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] key_one_o,
  output logic [7:0] key_two_o,
  output logic [7:0] key_three_o,
  output logic [7:0] key_four_o,
  output logic [2:0] layer_now_o,
  output logic       caps_led_on_o,
  output logic [1:0] media_key_o
);
  import kmld_pkg::*;

  logic [2:0]       layer_q, layer_d;
  logic             caps_q, caps_d, seen_q;
  logic             take, last;
  logic [1:0]       map;
  logic [Rows-1:0]  hit;
  code_t            code [Rows];
  code_t            slot [Slots];
  logic [1:0]       media_d;
  logic             ovalid_q;
  code_t            k1_q, k2_q, k3_q, k4_q;
  logic [2:0]       lay_q;
  logic             cap_q;
  logic [1:0]       med_q;

  assign in_ready_o = !frame_end_i || !ovalid_q || out_ready_i;
  assign take = in_valid_i && in_ready_o;
  assign last = frame_end_i;
  assign map  = map_for_layer(layer_q);

  for (genvar r = 0; r < Rows; r++) begin : g_lane
    kmld_row_lane #(.Row(r)) u_lane (
      .map_i (map),
      .col_i (column_index_i),
      .hit_i (row_pressed_i[r] && (32'(column_index_i) < Cols)),
      .hit_o (hit[r]),
      .code_o(code[r])
    );
  end

  kmld_slot_merge #(.Rows(Rows), .Slots(Slots)) u_merge (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .last_i(last),
    .hit_i (hit),
    .code_i(code),
    .slot_o(slot)
  );

  always_comb begin
    caps_d = (seen_q && slot[0] != CodeCaps) ? !caps_q : caps_q;
    layer_d = caps_d ? LayerUpper : LayerLower;
    if (slot[0] == CodeFn) begin
      layer_d = LayerFn;
      if (slot[1] == CodeFnQ) layer_d = LayerFnQ;
      else if (slot[1] == CodeFnW) layer_d = LayerMedia;
      else if (slot[1] == CodeFnE) layer_d = LayerFnE;
    end
    media_d = MediaNone;
    if (layer_d == LayerMedia) begin
      if (slot[2] == CodeFn) media_d = MediaUp;
      else if (slot[2] == CodeFnQ) media_d = MediaDown;
      else if (slot[2] == CodeFnW) media_d = MediaMute;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_q  <= LayerLower;
      caps_q   <= 1'b0;
      seen_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (take && last) begin
        layer_q  <= layer_d;
        caps_q   <= caps_d;
        seen_q   <= (slot[0] == CodeCaps);
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q  <= 8'h00;
      k2_q  <= 8'h00;
      k3_q  <= 8'h00;
      k4_q  <= 8'h00;
      lay_q <= LayerLower;
      cap_q <= 1'b0;
      med_q <= MediaNone;
    end else if (take && last) begin
      k1_q  <= slot[0];
      k2_q  <= slot[1];
      k3_q  <= slot[2];
      k4_q  <= (Slots > 3) ? slot[Slots > 3 ? 3 : 0] : 8'h00;
      lay_q <= layer_d;
      cap_q <= caps_d;
      med_q <= media_d;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign key_one_o     = k1_q;
  assign key_two_o     = k2_q;
  assign key_three_o   = k3_q;
  assign key_four_o    = k4_q;
  assign layer_now_o   = lay_q;
  assign caps_led_on_o = cap_q;
  assign media_key_o   = med_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) layer_q <= LayerFnE)
    else $error("unreachable layer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_one_o))
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && media_key_o != MediaNone |-> layer_now_o == LayerMedia)
    else $error("media key outside media layer");
endmodule

@@ sv/kmld_row_lane.sv @@
// one row lane: keymap lookup for a single matrix row
// depends on kmld_pkg
module kmld_row_lane #(
  parameter int unsigned Row = 0
) (
  input  logic [1:0]          map_i,
  input  logic [3:0]          col_i,
  input  logic                hit_i,
  output logic                hit_o,
  output kmld_pkg::code_t     code_o
);
  import kmld_pkg::*;

  assign hit_o  = hit_i;
  assign code_o = hit_i ? keymap(map_i, 3'(Row), col_i) : 8'h00;
endmodule

@@ sv/kmld_slot_merge.sv @@
// merges lane hits into the slot file in row order, holds frame state
// depends on kmld_pkg
module kmld_slot_merge #(
  parameter int unsigned Rows  = kmld_pkg::RowsDef,
  parameter int unsigned Slots = kmld_pkg::SlotsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  logic                      last_i,
  input  logic [Rows-1:0]           hit_i,
  input  kmld_pkg::code_t           code_i [Rows],
  output kmld_pkg::code_t           slot_o [Slots]
);
  import kmld_pkg::*;
  localparam int unsigned CntW = $clog2(Slots + 1);
  localparam int unsigned IdxW = $clog2(Slots);

  code_t           slot_q [Slots];
  code_t           slot_d [Slots];
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    for (int r = 0; r < Rows; r++) begin
      if (hit_i[r] && (32'(cnt_d) < Slots)) begin
        slot_d[cnt_d[IdxW-1:0]] = code_i[r];
        cnt_d = cnt_d + 1'b1;
      end
    end
  end

  // slot_o carries this beat's keys too, for the frame end
  assign slot_o = slot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int s = 0; s < Slots; s++) slot_q[s] <= 8'h00;
    end else if (take_i) begin
      if (last_i) begin
        cnt_q <= '0;
        for (int s = 0; s < Slots; s++) slot_q[s] <= 8'h00;
      end else begin
        cnt_q  <= cnt_d;
        slot_q <= slot_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(cnt_q) <= Slots)
    else $error("slot count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && last_i |=> cnt_q == '0)
    else $error("slots not cleared at frame end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_i |=> $stable(cnt_q))
    else $error("slot count moved without a beat");
endmodule
